/* rtl/bbs_pkg.sv */
// Shared types, constants and control bundle of the Blum Blum Shub generator.
package bbs_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] t_word;

    // The two primes whose product is the modulus out of reset.
    localparam longint unsigned PRIME_P = 33617;
    localparam longint unsigned PRIME_Q = 5011;
    localparam t_word MOD_RESET = t_word'(PRIME_P * PRIME_Q);

    // Operation codes of an input word.
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Iteration counts of the three passes through the shared adder.
    localparam int MUL_STEPS  = WORD_W;
    localparam int DIV_STEPS  = 2 * WORD_W;
    localparam int FRAC_STEPS = WORD_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // Control from the sequencer to the arithmetic core.
    typedef struct packed {
        logic ld_mul;     // load the state as multiplier and multiplicand
        logic ld_div;     // move the product into the dividend register
        logic mul_step;   // one shift-and-add step
        logic div_step;   // one restoring division step
        logic frac_mode;  // division shifts in zeros (value * 2^32)
    } t_core_ctrl;

endpackage

/* rtl/bbs_if.sv */
// Valid/ready channel interfaces for the input and result words.
interface bbs_in_if;
    import bbs_pkg::*;

    logic  valid;
    logic  ready;
    logic  op;
    t_word seed;

    modport source (output valid, output op, output seed, input ready);
    modport sink   (input valid, input op, input seed, output ready);
endinterface

interface bbs_out_if;
    import bbs_pkg::*;

    logic  valid;
    logic  ready;
    t_word value;
    t_word fraction;

    modport source (output valid, output value, output fraction, input ready);
    modport sink   (input valid, input value, input fraction, output ready);
endinterface

/* rtl/bbs_core.sv */
// Shift-and-add multiplier and restoring divider sharing one 34-bit adder.
module bbs_core (
    input  logic                i_clk,
    input  bbs_pkg::t_core_ctrl i_ctrl,
    input  bbs_pkg::t_word      i_state,
    input  bbs_pkg::t_word      i_mod,
    output bbs_pkg::t_word      o_rem,
    output bbs_pkg::t_word      o_quo
);
    import bbs_pkg::*;

    t_word                r_hi;   // product high half, then partial remainder
    logic [2*WORD_W-1:0]  r_lo;   // product low half, then dividend / quotient
    t_word                r_m;    // multiplicand

    logic                 div_bit;
    logic [WORD_W:0]      trial;
    logic [WORD_W:0]      op_a;
    logic [WORD_W:0]      op_b;
    logic [WORD_W+1:0]    res;
    logic                 fits;

    // In fraction mode the dividend is value * 2^32, so only zeros come in.
    assign div_bit = i_ctrl.frac_mode ? 1'b0 : r_lo[2*WORD_W-1];
    assign trial   = {r_hi, div_bit};

    always_comb begin
        if (i_ctrl.mul_step) begin
            op_a = {1'b0, r_hi};
            op_b = r_lo[0] ? {1'b0, r_m} : '0;
            res  = {1'b0, op_a} + {1'b0, op_b};
        end else begin
            op_a = trial;
            op_b = {1'b0, i_mod};
            res  = {1'b0, op_a} + ~{1'b0, op_b} + {{(WORD_W+1){1'b0}}, 1'b1};
        end
    end

    // The difference is negative exactly when its top bit is set.
    assign fits = ~res[WORD_W+1];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_mul) begin
            r_m  <= i_state;
            r_hi <= '0;
            r_lo <= {{WORD_W{1'b0}}, i_state};
        end else if (i_ctrl.ld_div) begin
            r_lo <= {r_hi, r_lo[WORD_W-1:0]};
            r_hi <= '0;
        end else if (i_ctrl.mul_step) begin
            r_hi             <= res[WORD_W:1];
            r_lo[WORD_W-1:0] <= {res[0], r_lo[WORD_W-1:1]};
        end else if (i_ctrl.div_step) begin
            r_hi <= fits ? res[WORD_W-1:0] : trial[WORD_W-1:0];
            r_lo <= {r_lo[2*WORD_W-2:0], fits};
        end
    end

    assign o_rem = r_hi;
    assign o_quo = r_lo[WORD_W-1:0];

endmodule

/* rtl/blum_blum_shub_generator_unit.sv */
// Blum Blum Shub generator: sequencer, state, modulus and result register.
// A load word gives no result. A step word's result is registered after 32 multiply steps,
// one transfer, 64 remainder steps, 32 fraction steps and one output load, all through one
// shared 34-bit adder; the next word is taken only after that result is registered, and
// later while a previous result still waits. A zero modulus skips the passes and gives a
// zero result. Synchronous active-low
// reset sets the state to 0, the modulus to 33617 * 5011 and empties the result register.
module blum_blum_shub_generator_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  bbs_pkg::t_word i_cfg_wr_data,
    bbs_in_if.sink         i_in,
    bbs_out_if.source      o_out
);
    import bbs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_XFER = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FRAC = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_word              r_cur, n_cur;
    t_word              r_mod;
    logic               r_zero, n_zero;
    logic               r_out_valid, n_out_valid;
    t_word              r_out_value, n_out_value;
    t_word              r_out_frac, n_out_frac;

    t_core_ctrl         ctrl;
    t_word              core_rem;
    t_word              core_quo;
    logic               in_acc;
    logic               out_free;

    bbs_core u_core (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_state (r_cur),
        .i_mod   (r_mod),
        .o_rem   (core_rem),
        .o_quo   (core_quo)
    );

    // Inputs are taken only between step words; a waiting result does not block them.
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    // The modulus is to be written only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_mod <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_zero      = r_zero;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_frac  = r_out_frac;
        ctrl        = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.op == OP_LOAD) begin
                        // The seed goes in unreduced; the next square takes care of it.
                        n_cur = i_in.seed;
                    end else if (r_mod == '0) begin
                        // No reduction exists, so the state and both outputs become zero.
                        n_cur   = '0;
                        n_zero  = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        ctrl.ld_mul = 1'b1;
                        n_zero      = 1'b0;
                        n_cnt       = CNT_W'(MUL_STEPS - 1);
                        n_state     = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                ctrl.mul_step = 1'b1;
                n_cnt         = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_XFER;
                end
            end
            ST_XFER: begin
                ctrl.ld_div = 1'b1;
                n_cnt       = CNT_W'(DIV_STEPS - 1);
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                ctrl.div_step = 1'b1;
                n_cnt         = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_cnt   = CNT_W'(FRAC_STEPS - 1);
                    n_state = ST_FRAC;
                end
            end
            ST_FRAC: begin
                // The remainder is the new state; grab it before the fraction
                // pass starts overwriting the partial remainder.
                if (r_cnt == CNT_W'(FRAC_STEPS - 1)) begin
                    n_cur = core_rem;
                end
                ctrl.div_step  = 1'b1;
                ctrl.frac_mode = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Wait here only if the previous result has not been taken yet.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_cur;
                    n_out_frac  = r_zero ? '0 : core_quo;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_cur       <= '0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cur       <= n_cur;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_frac  <= n_out_frac;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.value    = r_out_value;
    assign o_out.fraction = r_out_frac;

    // A step word with a usable modulus starts the multiply pass right away.
    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.op == OP_STEP && r_mod != '0) |=> (r_state == ST_MUL))
        else $error("step word did not start the multiply pass");

    // A load word never leaves the idle state.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.op == OP_LOAD) |=> (r_state == ST_IDLE))
        else $error("load word left the idle state");

    // The partial remainder stays below the modulus during the remainder pass.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_mod != '0) |-> (core_rem < r_mod))
        else $error("partial remainder reached the modulus");

    // A new result appears only on leaving the done state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result registered outside the done state");

endmodule
